// ===== rtl/core/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// KMP next table builder package
// Shared item classes, sequencer states and output constants.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int OUT_W = 9;

	localparam logic signed [OUT_W-1:0] NEXT_NONE = -9'sd1;
	localparam logic signed [OUT_W-1:0] NEXT_ZERO = 9'sd0;

	typedef enum logic [1:0] {
		K_FIRST,
		K_NORM,
		K_OVER
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FALL,
		B_LOOK
	} bstate_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_v;
	} cls_t;

endpackage

// ===== rtl/core/kmp_in_if.sv =====
// ----------------------------------------------------------------------------
// Pattern byte channel
// Valid/ready channel carrying one pattern byte and its start flag.
// ----------------------------------------------------------------------------
interface kmp_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] pattern_byte;
	logic       first_byte;

	modport source (output valid, output pattern_byte, output first_byte, input ready);
	modport sink (input valid, input pattern_byte, input first_byte, output ready);

endinterface

// ===== rtl/core/kmp_out_if.sv =====
// ----------------------------------------------------------------------------
// Next value channel
// Valid/ready channel carrying one position and its next table entry.
// ----------------------------------------------------------------------------
interface kmp_out_if;

	logic              valid;
	logic              ready;
	logic [8:0]        position;
	logic signed [8:0] next_value;
	logic              overflow;

	modport source (output valid, output position, output next_value, output overflow,
		input ready);
	modport sink (input valid, input position, input next_value, input overflow,
		output ready);

endinterface

// ===== rtl/core/kmp_front.sv =====
// ----------------------------------------------------------------------------
// KMP front end
// Accepts pattern bytes, tracks the write position and classifies each byte.
// ----------------------------------------------------------------------------
module kmp_front #(
	parameter int MAX_LEN = 256,
	parameter int PW      = $clog2(MAX_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	kmp_in_if.sink        item,
	output logic          q_push,
	input  logic          q_full,
	output kmp_pkg::cls_t q_cls,
	output logic [PW-1:0] q_pos
);
	import kmp_pkg::*;

	localparam logic [PW-1:0] LIMIT = PW'(MAX_LEN);

	logic [PW-1:0] wp_q;
	logic [PW-1:0] pos;

	assign pos        = item.first_byte ? '0 : wp_q;
	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;
	assign q_pos      = pos;

	always_comb begin
		q_cls.byte_v = item.pattern_byte;
		if (pos == LIMIT) begin
			q_cls.kind = K_OVER;
		end else if (pos == '0) begin
			q_cls.kind = K_FIRST;
		end else begin
			q_cls.kind = K_NORM;
		end
	end

	// saturate at the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (q_push) begin
			wp_q <= (pos == LIMIT) ? pos : pos + PW'(1);
		end
	end

endmodule

// ===== rtl/core/kmp_queue.sv =====
// ----------------------------------------------------------------------------
// KMP decoupling queue
// Small FIFO between the front end and the table sequencer.
// ----------------------------------------------------------------------------
module kmp_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/kmp_back.sv =====
// ----------------------------------------------------------------------------
// KMP table sequencer
// Holds the pattern and next tables, walks the fallback chain and emits.
// ----------------------------------------------------------------------------
module kmp_back #(
	parameter int MAX_LEN = 256,
	parameter int PW      = $clog2(MAX_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  kmp_pkg::cls_t q_cls,
	input  logic [PW-1:0] q_pos,
	kmp_out_if.source     result
);
	import kmp_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int VW = AW + 1;

	logic [7:0]        pmem [MAX_LEN];
	logic signed [AW:0] nmem [MAX_LEN];

	bstate_t           state_q;
	bstate_t           state_d;
	logic [7:0]        p_rd_q;
	logic signed [AW:0] n_rd_q;
	logic [7:0]        cur_byte_q;
	logic [PW-1:0]     cur_pos_q;
	logic [7:0]        prev_q;
	logic [7:0]        last_q;
	logic signed [AW:0] k_q;
	logic signed [AW:0] k_d;
	logic signed [AW:0] ml_q;
	logic signed [AW:0] k_start;
	logic signed [AW:0] k_inc;
	logic signed [AW:0] look_val;

	logic              res_valid_q;
	logic [8:0]        res_pos_q;
	logic signed [8:0] res_next_q;
	logic              res_ovf_q;

	logic              finish_ok;
	logic              look_done;
	logic              start_norm;
	logic              fall_hit;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [7:0]        wr_byte;
	logic signed [AW:0] wr_val;
	logic              emit;
	logic [PW+8:0]     pos_ext;
	logic [VW+8:0]     val_ext;

	assign finish_ok  = !res_valid_q || result.ready;
	assign look_done  = (state_q == B_LOOK) && finish_ok;
	assign k_start    = look_done ? k_q : ml_q;
	assign k_inc      = k_q + VW'(1);
	assign fall_hit   = (p_rd_q == prev_q);
	assign look_val   = (p_rd_q == cur_byte_q) ? n_rd_q : k_q;

	always_comb begin
		q_pop = 1'b0;
		if (q_valid) begin
			if (state_q == B_IDLE) begin
				q_pop = (q_cls.kind == K_NORM) || finish_ok;
			end else if (look_done) begin
				q_pop = (q_cls.kind == K_NORM);
			end
		end
	end

	assign start_norm = q_pop && (q_cls.kind == K_NORM);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (start_norm) begin
					state_d = k_start[AW] ? B_LOOK : B_FALL;
				end
			end
			B_FALL: begin
				if (fall_hit || n_rd_q[AW]) begin
					state_d = B_LOOK;
				end
			end
			B_LOOK: begin
				if (start_norm) begin
					state_d = k_start[AW] ? B_LOOK : B_FALL;
				end else if (look_done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		k_d     = k_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_byte = q_cls.byte_v;
		wr_val  = '1;
		emit    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_pop && q_cls.kind == K_FIRST) begin
					wr_en = 1'b1;
				end
				emit = q_pop && (q_cls.kind != K_NORM);
			end
			B_FALL: begin
				rd_en = 1'b1;
				if (fall_hit) begin
					k_d = k_inc;
				end else if (n_rd_q[AW]) begin
					k_d = '0;
				end else begin
					k_d = n_rd_q;
				end
				rd_addr = k_d[AW-1:0];
			end
			B_LOOK: begin
				if (look_done) begin
					wr_en   = 1'b1;
					wr_addr = cur_pos_q[AW-1:0];
					wr_byte = cur_byte_q;
					wr_val  = look_val;
					emit    = 1'b1;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		if (start_norm) begin
			rd_en   = 1'b1;
			k_d     = k_start[AW] ? '0 : k_start;
			rd_addr = k_d[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pmem[wr_addr] <= wr_byte;
			nmem[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			p_rd_q <= pmem[rd_addr];
			n_rd_q <= nmem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_norm) begin
			cur_byte_q <= q_cls.byte_v;
			cur_pos_q  <= q_pos;
			prev_q     <= wr_en ? wr_byte : last_q;
		end
		if (wr_en) begin
			last_q <= wr_byte;
		end
		k_q <= k_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ml_q    <= '1;
		end else begin
			state_q <= state_d;
			if (look_done) begin
				ml_q <= k_q;
			end else if (q_pop && q_cls.kind == K_FIRST) begin
				ml_q <= '1;
			end
		end
	end

	assign pos_ext = look_done ? {9'd0, cur_pos_q} : {9'd0, q_pos};
	assign val_ext = {{9{look_val[AW]}}, look_val};

	always_ff @(posedge clk) begin
		if (emit) begin
			res_pos_q <= pos_ext[8:0];
			res_ovf_q <= !look_done && (q_cls.kind == K_OVER);
			if (look_done) begin
				res_next_q <= val_ext[8:0];
			end else if (q_cls.kind == K_FIRST) begin
				res_next_q <= NEXT_NONE;
			end else begin
				res_next_q <= NEXT_ZERO;
			end
		end
	end

	// hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.position   = res_pos_q;
	assign result.next_value = res_next_q;
	assign result.overflow   = res_ovf_q;

endmodule

// ===== rtl/core/kmp_next_table_builder.sv =====
// ----------------------------------------------------------------------------
// KMP next table builder
// Streaming builder of the optimised KMP nextval table, one byte per transfer.
// ----------------------------------------------------------------------------
// Each pattern byte gives one result: its position and its nextval entry (-1
// at position 0). A first byte or a byte past MAX_LEN (overflow, not stored)
// is emitted from the idle state; any other byte reads the tables and, when a
// match is held, walks the fallback chain in B_FALL, one step per read of the
// single read port of the pattern and next tables, then ends in B_LOOK; with
// no match held it goes straight to B_LOOK. Fallback is amortised. A two-entry
// queue lets bytes be taken while the sequencer works, and an output register
// holds a result until its transfer. The tables need no clearing after reset.
module kmp_next_table_builder #(
	parameter int MAX_LEN = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	kmp_in_if.sink    item,
	kmp_out_if.source result
);
	import kmp_pkg::*;

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int QW = $bits(cls_t) + PW;

	logic          q_push;
	logic          q_full;
	cls_t          f_cls;
	logic [PW-1:0] f_pos;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_data;
	cls_t          b_cls;
	logic [PW-1:0] b_pos;

	kmp_front #(.MAX_LEN(MAX_LEN), .PW(PW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_push (q_push),
		.q_full (q_full),
		.q_cls  (f_cls),
		.q_pos  (f_pos)
	);

	kmp_queue #(.W(QW), .DEPTH(2)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_cls, f_pos}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	assign b_cls = cls_t'(q_data[QW-1:PW]);
	assign b_pos = q_data[PW-1:0];

	kmp_back #(.MAX_LEN(MAX_LEN), .PW(PW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_cls   (b_cls),
		.q_pos   (b_pos),
		.result  (result)
	);

endmodule

// ===== rtl/core/kmp_checker.sv =====
// ----------------------------------------------------------------------------
// KMP next table builder checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kmp_checker #(
	parameter int MAX_LEN = 256
) (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [8:0]        position,
	input logic signed [8:0] next_value,
	input logic              overflow
);
	import kmp_pkg::*;

	localparam logic [8:0] LIMIT_POS = 9'(MAX_LEN);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(position) && $stable(next_value))
		else $error("result dropped before transfer");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> position == LIMIT_POS && next_value == NEXT_ZERO)
		else $error("overflow result malformed");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !overflow && position == 9'd0 && MAX_LEN <= 512
		|-> next_value == NEXT_NONE)
		else $error("position zero without -1");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !overflow && position != 9'd0 && MAX_LEN <= 256
		|-> $signed({next_value[8], next_value}) < $signed({1'b0, position}))
		else $error("next value not below position");

endmodule

bind kmp_next_table_builder kmp_checker #(.MAX_LEN(MAX_LEN)) u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.position   (result.position),
	.next_value (result.next_value),
	.overflow   (result.overflow)
);
